### design/chs_pkg.sv
`default_nettype none

package chs_pkg;

  // Field widths of the stream payload
  localparam int KEY_W     = 31;
  localparam int REQ_W     = 2;
  localparam int ST_W      = 3;
  localparam int BKT_OUT_W = 4;
  localparam int POS_OUT_W = 3;

  localparam int S_TDATA_W = 32;
  localparam int S_TUSER_W = 2;
  localparam int M_TDATA_W = 8;
  localparam int M_TUSER_W = 3;

  // Default geometry
  localparam int CHS_NUM_BUCKETS = 10;
  localparam int CHS_CHAIN_DEPTH = 8;

  // Remainder unit: key padded to 32 bits, 4 bits folded in per cycle
  localparam int HASH_W    = 32;
  localparam int HASH_STEP = 4;
  localparam int HASH_CYC  = HASH_W / HASH_STEP;
  localparam int HCW       = $clog2(HASH_CYC);

  // Request codes
  localparam logic [REQ_W-1:0] REQ_APPEND = 2'd0;
  localparam logic [REQ_W-1:0] REQ_SORTED = 2'd1;
  localparam logic [REQ_W-1:0] REQ_DELETE = 2'd2;
  localparam logic [REQ_W-1:0] REQ_LOOKUP = 2'd3;

  // Status codes
  localparam logic [ST_W-1:0] ST_INSERTED = 3'd0;
  localparam logic [ST_W-1:0] ST_PRESENT  = 3'd1;
  localparam logic [ST_W-1:0] ST_DELETED  = 3'd2;
  localparam logic [ST_W-1:0] ST_ABSENT   = 3'd3;
  localparam logic [ST_W-1:0] ST_FULL     = 3'd4;

  // Chain edit that follows the walk
  localparam logic [1:0] OP_NONE = 2'd0;
  localparam logic [1:0] OP_INS  = 2'd1;
  localparam logic [1:0] OP_DEL  = 2'd2;

  typedef struct packed {
    logic clr_wr;
    logic load_in;
    logic hash_step;
    logic len_rd;
    logic len_load;
    logic walk_rd;
    logic walk_cmp;
    logic decide;
    logic mv_rd;
    logic mv_wr;
    logic update;
    logic out_load;
  } ctl_cmd_t;

  typedef struct packed {
    logic clr_last;
    logic hash_last;
    logic walk_done;
    logic mv_done;
    logic out_free;
  } ctl_stat_t;

endpackage

`default_nettype wire

### design/chs_ram.sv
`default_nettype none

module chs_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  wire logic                                      clk,
  input  wire logic                                      we,
  input  wire logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
  input  wire logic [WIDTH-1:0]                          wdata,
  input  wire logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
  output logic      [WIDTH-1:0]                          rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

`default_nettype wire

### design/chs_ctrl.sv
`default_nettype none

module chs_ctrl
  import chs_pkg::*;
(
  input  wire logic      clk,
  input  wire logic      rst,
  input  wire logic      s_tvalid,
  output logic           s_tready,
  input  wire ctl_stat_t stat,
  output ctl_cmd_t       cmd
);

  localparam logic [3:0] S_CLEAR    = 4'd0;
  localparam logic [3:0] S_IDLE     = 4'd1;
  localparam logic [3:0] S_HASH     = 4'd2;
  localparam logic [3:0] S_LEN_RD   = 4'd3;
  localparam logic [3:0] S_LEN_WT   = 4'd4;
  localparam logic [3:0] S_WALK_RD  = 4'd5;
  localparam logic [3:0] S_WALK_CMP = 4'd6;
  localparam logic [3:0] S_DECIDE   = 4'd7;
  localparam logic [3:0] S_MOVE_RD  = 4'd8;
  localparam logic [3:0] S_MOVE_WR  = 4'd9;
  localparam logic [3:0] S_UPDATE   = 4'd10;
  localparam logic [3:0] S_FINISH   = 4'd11;

  logic [3:0] state;
  logic [3:0] state_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_CLEAR;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    cmd        = '0;
    s_tready   = 1'b0;
    case (state)
      S_CLEAR: begin
        cmd.clr_wr = 1'b1;
        if (stat.clr_last) state_next = S_IDLE;
      end
      S_IDLE: begin
        s_tready    = 1'b1;
        cmd.load_in = s_tvalid;
        if (s_tvalid) state_next = S_HASH;
      end
      S_HASH: begin
        cmd.hash_step = 1'b1;
        if (stat.hash_last) state_next = S_LEN_RD;
      end
      S_LEN_RD: begin
        cmd.len_rd = 1'b1;
        state_next = S_LEN_WT;
      end
      S_LEN_WT: begin
        cmd.len_load = 1'b1;
        state_next   = S_WALK_RD;
      end
      S_WALK_RD: begin
        if (stat.walk_done) begin
          state_next = S_DECIDE;
        end else begin
          cmd.walk_rd = 1'b1;
          state_next  = S_WALK_CMP;
        end
      end
      S_WALK_CMP: begin
        cmd.walk_cmp = 1'b1;
        state_next   = S_WALK_RD;
      end
      S_DECIDE: begin
        cmd.decide = 1'b1;
        state_next = S_MOVE_RD;
      end
      S_MOVE_RD: begin
        if (stat.mv_done) begin
          state_next = S_UPDATE;
        end else begin
          cmd.mv_rd  = 1'b1;
          state_next = S_MOVE_WR;
        end
      end
      S_MOVE_WR: begin
        cmd.mv_wr  = 1'b1;
        state_next = S_MOVE_RD;
      end
      S_UPDATE: begin
        cmd.update = 1'b1;
        state_next = S_FINISH;
      end
      S_FINISH: begin
        if (stat.out_free) begin
          cmd.out_load = 1'b1;
          state_next   = S_IDLE;
        end
      end
      default: begin
        state_next = S_CLEAR;
      end
    endcase
  end

endmodule

`default_nettype wire

### design/chs_dp.sv
`default_nettype none

module chs_dp
  import chs_pkg::*;
#(
  parameter int NUM_BUCKETS = CHS_NUM_BUCKETS,
  parameter int CHAIN_DEPTH = CHS_CHAIN_DEPTH
) (
  input  wire logic             clk,
  input  wire logic             rst,
  input  wire ctl_cmd_t         cmd,
  output ctl_stat_t             stat,
  input  wire logic [KEY_W-1:0] in_key,
  input  wire logic [REQ_W-1:0] in_req,
  output logic                  m_tvalid,
  input  wire logic             m_tready,
  output logic [M_TDATA_W-1:0]  m_tdata,
  output logic [M_TUSER_W-1:0]  m_tuser
);

  localparam int BW    = $clog2(NUM_BUCKETS);
  localparam int LW    = $clog2(CHAIN_DEPTH + 1);
  localparam int SLOTS = NUM_BUCKETS * CHAIN_DEPTH;
  localparam int AW    = $clog2(SLOTS);
  localparam logic [BW:0]   NB_C   = (BW+1)'(NUM_BUCKETS);
  localparam logic [LW-1:0] FULL_C = LW'(CHAIN_DEPTH);

  logic [KEY_W-1:0]  key_q;
  logic [REQ_W-1:0]  req_q;
  logic [HASH_W-1:0] hsh;
  logic [HCW-1:0]    hcnt;
  logic [BW-1:0]     rem;
  logic [BW-1:0]     rem_next;
  logic [AW-1:0]     base;
  logic [LW-1:0]     len;
  logic [LW-1:0]     j;
  logic              found;
  logic [LW-1:0]     fidx;
  logic              sset;
  logic [LW-1:0]     spos;
  logic [LW-1:0]     pos;
  logic [ST_W-1:0]   st;
  logic [1:0]        op;
  logic [BW-1:0]     clr_cnt;

  logic [ST_W-1:0]   st_next;
  logic [LW-1:0]     pos_next;
  logic [1:0]        op_next;
  logic [LW-1:0]     j_next;

  logic [BW:0]       fold;
  logic [BW-1:0]     racc;

  logic [LW-1:0]     rd_idx;
  logic [AW-1:0]     key_raddr;
  logic [KEY_W-1:0]  key_rdata;
  logic              key_we;
  logic [AW-1:0]     key_waddr;
  logic [KEY_W-1:0]  key_wdata;
  logic              len_we;
  logic [BW-1:0]     len_waddr;
  logic [LW-1:0]     len_wdata;
  logic [LW-1:0]     len_rdata;

  logic [BW+BKT_OUT_W-1:0] bkt_ext;
  logic [LW+POS_OUT_W-1:0] pos_ext;

  // Remainder fold, one key bit per step
  always_comb begin
    racc = rem;
    fold = '0;
    for (int i = 0; i < HASH_STEP; i++) begin
      fold = {racc, hsh[HASH_W-1-i]};
      if (fold >= NB_C) fold = fold - NB_C;
      racc = fold[BW-1:0];
    end
    rem_next = racc;
  end

  // Outcome of the walk
  always_comb begin
    st_next  = ST_ABSENT;
    pos_next = '0;
    op_next  = OP_NONE;
    j_next   = j;
    case (req_q)
      REQ_APPEND, REQ_SORTED: begin
        if (found) begin
          st_next  = ST_PRESENT;
          pos_next = fidx;
        end else if (len == FULL_C) begin
          st_next = ST_FULL;
        end else begin
          st_next  = ST_INSERTED;
          op_next  = OP_INS;
          pos_next = (req_q == REQ_APPEND) ? len : spos;
          j_next   = len;
        end
      end
      REQ_DELETE: begin
        if (found) begin
          st_next  = ST_DELETED;
          pos_next = fidx;
          op_next  = OP_DEL;
          j_next   = fidx;
        end
      end
      default: begin
        if (found) begin
          st_next  = ST_PRESENT;
          pos_next = fidx;
        end
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (cmd.load_in) begin
      key_q <= in_key;
      req_q <= in_req;
      hsh   <= {1'b0, in_key};
      hcnt  <= '0;
      rem   <= '0;
    end
    if (cmd.hash_step) begin
      rem  <= rem_next;
      hsh  <= hsh << HASH_STEP;
      hcnt <= hcnt + 1'b1;
    end
    if (cmd.len_rd) begin
      base <= AW'(rem) * AW'(CHAIN_DEPTH);
    end
    if (cmd.len_load) begin
      len   <= len_rdata;
      spos  <= len_rdata;
      j     <= '0;
      found <= 1'b0;
      sset  <= 1'b0;
      fidx  <= '0;
    end
    if (cmd.walk_cmp) begin
      if (!found && key_rdata == key_q) begin
        found <= 1'b1;
        fidx  <= j;
      end
      if (!sset && key_q <= key_rdata) begin
        sset <= 1'b1;
        spos <= j;
      end
      j <= j + 1'b1;
    end
    if (cmd.decide) begin
      st  <= st_next;
      pos <= pos_next;
      op  <= op_next;
      j   <= j_next;
    end
    if (cmd.mv_wr) begin
      j <= (op == OP_INS) ? j - 1'b1 : j + 1'b1;
    end
  end

  // Clear sweep over the length table
  always_ff @(posedge clk) begin
    if (rst) begin
      clr_cnt <= '0;
    end else if (cmd.clr_wr) begin
      clr_cnt <= clr_cnt + 1'b1;
    end
  end

  assign rd_idx    = cmd.walk_rd ? j : ((op == OP_INS) ? j - 1'b1 : j + 1'b1);
  assign key_raddr = base + AW'(rd_idx);
  assign key_we    = cmd.mv_wr || (cmd.update && op == OP_INS);
  assign key_waddr = base + AW'(cmd.mv_wr ? j : pos);
  assign key_wdata = cmd.mv_wr ? key_rdata : key_q;

  assign len_we    = cmd.clr_wr || (cmd.update && op != OP_NONE);
  assign len_waddr = cmd.clr_wr ? clr_cnt : rem;
  assign len_wdata = cmd.clr_wr ? '0 : ((op == OP_INS) ? len + 1'b1 : len - 1'b1);

  chs_ram #(
    .WIDTH (KEY_W),
    .DEPTH (SLOTS)
  ) u_keys (
    .clk   (clk),
    .we    (key_we),
    .waddr (key_waddr),
    .wdata (key_wdata),
    .raddr (key_raddr),
    .rdata (key_rdata)
  );

  chs_ram #(
    .WIDTH (LW),
    .DEPTH (NUM_BUCKETS)
  ) u_lens (
    .clk   (clk),
    .we    (len_we),
    .waddr (len_waddr),
    .wdata (len_wdata),
    .raddr (rem),
    .rdata (len_rdata)
  );

  always_comb begin
    stat.clr_last  = (clr_cnt == BW'(NUM_BUCKETS - 1));
    stat.hash_last = (hcnt == HCW'(HASH_CYC - 1));
    stat.walk_done = (j == len);
    case (op)
      OP_INS:  stat.mv_done = (j == pos);
      OP_DEL:  stat.mv_done = (({1'b0, j} + 1'b1) >= {1'b0, len});
      default: stat.mv_done = 1'b1;
    endcase
    stat.out_free  = !m_tvalid || m_tready;
  end

  // Result register
  assign bkt_ext = {{BKT_OUT_W{1'b0}}, rem};
  assign pos_ext = {{POS_OUT_W{1'b0}}, pos};

  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (cmd.out_load) begin
      m_tvalid <= 1'b1;
    end else if (m_tready) begin
      m_tvalid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.out_load) begin
      m_tuser <= st;
      m_tdata <= {1'b0, pos_ext[POS_OUT_W-1:0], bkt_ext[BKT_OUT_W-1:0]};
    end
  end

endmodule

`default_nettype wire

### design/chained_hash_set.sv
// Chained hash set: keeps unique 31-bit keys in NUM_BUCKETS buckets, each a
// chain of up to CHAIN_DEPTH entries, bucket = key mod NUM_BUCKETS.
// Request channel (s_*): one beat per request, req_type on s_tuser and key
// on s_tdata. Result channel (m_*): one beat per request with status on
// m_tuser, bucket and chain position on m_tdata.
// Requests are handled one at a time. The time from accept to result
// grows with L, the length of the chain walked, and with M, the number
// of entries shifted by an insert or delete: every entry visit is a read
// and then a compare, and every shift a read and then a write, through the
// single read port of the key memory, and the bucket index comes from a
// remainder unit that folds in 4 key bits per cycle.
// A finished result sits in the output register; the next request is taken
// while it waits, but its own result holds in the last state until the
// receiver takes the waiting beat, so a stalled receiver stalls the block.
// Reset: synchronous, active high. After reset the block sweeps all
// NUM_BUCKETS entries of the chain length table to zero, with s_tready low.
`default_nettype none

module chained_hash_set
  import chs_pkg::*;
#(
  parameter int NUM_BUCKETS = CHS_NUM_BUCKETS,
  parameter int CHAIN_DEPTH = CHS_CHAIN_DEPTH
) (
  input  wire logic                 clk,
  input  wire logic                 rst,
  input  wire logic                 s_tvalid,
  output logic                      s_tready,
  input  wire logic [S_TDATA_W-1:0] s_tdata,   // [30:0] key, [31] zero
  input  wire logic [S_TUSER_W-1:0] s_tuser,   // [1:0] req_type
  output logic                      m_tvalid,
  input  wire logic                 m_tready,
  output logic [M_TDATA_W-1:0]      m_tdata,   // [3:0] bucket, [6:4] position, [7] zero
  output logic [M_TUSER_W-1:0]      m_tuser    // [2:0] status
);

  ctl_cmd_t  cmd;
  ctl_stat_t stat;

  // Sequencer: walks each request through hash, chain walk, shift, write-back
  chs_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .stat     (stat),
    .cmd      (cmd)
  );

  // Datapath: remainder unit, key and length memories, result register
  chs_dp #(
    .NUM_BUCKETS (NUM_BUCKETS),
    .CHAIN_DEPTH (CHAIN_DEPTH)
  ) u_dp (
    .clk      (clk),
    .rst      (rst),
    .cmd      (cmd),
    .stat     (stat),
    .in_key   (s_tdata[KEY_W-1:0]),
    .in_req   (s_tuser[REQ_W-1:0]),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tuser  (m_tuser)
  );

endmodule

`default_nettype wire

### design/chs_checker.sv
`default_nettype none

module chs_checker
  import chs_pkg::*;
(
  input wire logic                 clk,
  input wire logic                 rst,
  input wire logic                 s_tvalid,
  input wire logic                 s_tready,
  input wire logic                 m_tvalid,
  input wire logic                 m_tready,
  input wire logic [M_TDATA_W-1:0] m_tdata,
  input wire logic [M_TUSER_W-1:0] m_tuser
);

  // A stalled result beat holds its payload
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tuser))
    else $error("result beat changed while stalled");

  // Full bucket and missing key report position zero
  a_pos_zero: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && (m_tuser == ST_FULL || m_tuser == ST_ABSENT) |-> m_tdata[6:4] == 3'd0)
    else $error("nonzero position with full or absent status");

  // One request in flight: ready drops after an accept
  a_one_req: assert property (@(posedge clk) disable iff (rst)
    s_tvalid && s_tready |=> !s_tready)
    else $error("request accepted while another is in flight");

  // Length sweep runs right after reset
  a_clear: assert property (@(posedge clk) disable iff (rst)
    $past(rst) |-> !s_tready)
    else $error("request taken during length sweep");

endmodule

bind chained_hash_set chs_checker u_chk (
  .clk      (clk),
  .rst      (rst),
  .s_tvalid (s_tvalid),
  .s_tready (s_tready),
  .m_tvalid (m_tvalid),
  .m_tready (m_tready),
  .m_tdata  (m_tdata),
  .m_tuser  (m_tuser)
);

`default_nettype wire
